### src/cpu_effective_address_unit_assert.svh
// Assertion macros used by the address unit sequencer.
// CEAU_ASSERT_IMP checks a same-cycle implication, CEAU_ASSERT_NXT a next-cycle one.
`ifndef CPU_EFFECTIVE_ADDRESS_UNIT_ASSERT_SVH
`define CPU_EFFECTIVE_ADDRESS_UNIT_ASSERT_SVH

`ifndef SYNTH
`define CEAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CEAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CEAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CEAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/ceau_pkg.sv
package ceau_pkg;

    // Addressing mode codes
    localparam logic [3:0] MODE_IMP = 4'd0;
    localparam logic [3:0] MODE_ACC = 4'd1;
    localparam logic [3:0] MODE_IMM = 4'd2;
    localparam logic [3:0] MODE_ZP  = 4'd3;
    localparam logic [3:0] MODE_ZPX = 4'd4;
    localparam logic [3:0] MODE_ZPY = 4'd5;
    localparam logic [3:0] MODE_REL = 4'd6;
    localparam logic [3:0] MODE_ABS = 4'd7;
    localparam logic [3:0] MODE_ABX = 4'd8;
    localparam logic [3:0] MODE_ABY = 4'd9;
    localparam logic [3:0] MODE_IND = 4'd10;
    localparam logic [3:0] MODE_IZX = 4'd11;
    localparam logic [3:0] MODE_IZY = 4'd12;
    localparam logic [3:0] MODE_WR  = 4'd13;

    localparam int ADDR_W = 16;

    typedef struct packed {
        logic [3:0]        mode;
        logic [ADDR_W-1:0] pc;
        logic [7:0]        reg_a;
        logic [7:0]        reg_x;
        logic [7:0]        reg_y;
        logic [7:0]        write_data;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] target_address;
        logic [ADDR_W-1:0] next_pc;
        logic              extra_cycle;
    } rsp_t;

    // Byte memory access from the sequencer
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // Finished request from the sequencer
    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } fin_t;

endpackage

### src/cpu_effective_address_unit.sv
// Channel  | Signals                  | Handshake
// ---------+--------------------------+---------------------------------------
// request  | start, busy, request     | taken on a clock edge with start && !busy
// result   | result_strobe, result    | valid for one cycle, always taken
//
// Implied, accumulator and immediate finish when taken; a memory write is done when
// taken and gives no strobe. Zero page and relative read one operand byte, absolute
// and absolute indexed two, indexed indirect and indirect indexed one plus two
// pointer bytes, and indirect two plus two, from the single-port byte memory. The
// result strobe rises in the cycle after the request's last cycle, when busy is low.
// The receiver cannot stall, so a result never holds off the next request.
// Reset clears the sequencer and the held target; memory contents are not cleared.
module cpu_effective_address_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ceau_pkg::req_t request,
    output logic           result_strobe,
    output ceau_pkg::rsp_t result
);

    ceau_pkg::mem_req_t mem;
    ceau_pkg::fin_t     fin;
    logic [7:0]         rdata;
    logic               strobe_reg;
    logic [15:0]        held_reg;
    ceau_pkg::rsp_t     result_reg;

    ceau_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .held    (held_reg),
        .rdata   (rdata),
        .busy    (busy),
        .mem     (mem),
        .fin     (fin)
    );

    ceau_ram #(
        .WIDTH (8),
        .DEPTH (1 << ceau_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .en    (mem.en),
        .we    (mem.we),
        .addr  (mem.addr),
        .wdata (mem.wdata),
        .rdata (rdata)
    );

    // Drive the strobe and keep the last target for implied mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            held_reg   <= 16'h0000;
        end
        else
        begin
            strobe_reg <= fin.valid;
            if (fin.valid)
                held_reg <= fin.rsp.target_address;
        end
    end

    // Register the result payload
    always_ff @(posedge clk)
    begin
        if (fin.valid)
            result_reg <= fin.rsp;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

### src/ceau_ram.sv
module ceau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry, read data registered
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem_reg[addr] <= wdata;
            else
                rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ceau_seq.sv
`include "cpu_effective_address_unit_assert.svh"

module ceau_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ceau_pkg::req_t    request,
    input  logic [15:0]       held,
    input  logic [7:0]        rdata,
    output logic              busy,
    output ceau_pkg::mem_req_t mem,
    output ceau_pkg::fin_t    fin
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_B0   = 3'd1;
    localparam logic [2:0] S_B1   = 3'd2;
    localparam logic [2:0] S_P0   = 3'd3;
    localparam logic [2:0] S_P1   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  mode_reg, mode_next;
    logic [15:0] npc_reg, npc_next;
    logic [7:0]  x_reg, x_next;
    logic [7:0]  y_reg, y_next;
    logic [7:0]  lo_reg, lo_next;
    logic [15:0] ptr_reg, ptr_next;

    logic [15:0] word;
    logic [7:0]  idx;
    logic [15:0] idx_sum;
    logic        page_cross;
    logic [7:0]  zp_x;
    logic [7:0]  zp_y;
    logic [15:0] rel_target;

    // Shared address arithmetic
    assign word       = {rdata, lo_reg};
    assign idx        = (mode_reg == ceau_pkg::MODE_ABX) ? x_reg : y_reg;
    assign idx_sum    = word + {8'h00, idx};
    assign page_cross = (idx_sum[15:8] != word[15:8]);
    assign zp_x       = rdata + x_reg;
    assign zp_y       = rdata + y_reg;
    assign rel_target = npc_reg + {{8{rdata[7]}}, rdata};

    assign busy = (state_reg != S_IDLE);

    // Walk operand and pointer bytes, at most one memory access per cycle
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        npc_next   = npc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        lo_next    = lo_reg;
        ptr_next   = ptr_reg;
        mem        = '0;
        fin        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = request.mode;
                    x_next    = request.reg_x;
                    y_next    = request.reg_y;
                    if (request.mode >= ceau_pkg::MODE_ABS && request.mode <= ceau_pkg::MODE_IND)
                        npc_next = request.pc + 16'd2;
                    else
                        npc_next = request.pc + 16'd1;
                    case (request.mode)
                        ceau_pkg::MODE_IMP:
                        begin
                            fin.valid              = 1'b1;
                            fin.rsp.target_address = held;
                            fin.rsp.next_pc        = request.pc;
                        end
                        ceau_pkg::MODE_ACC:
                        begin
                            fin.valid              = 1'b1;
                            fin.rsp.target_address = {8'h00, request.reg_a};
                            fin.rsp.next_pc        = request.pc;
                        end
                        ceau_pkg::MODE_IMM:
                        begin
                            fin.valid              = 1'b1;
                            fin.rsp.target_address = request.pc;
                            fin.rsp.next_pc        = request.pc + 16'd1;
                        end
                        ceau_pkg::MODE_WR:
                        begin
                            mem.en    = 1'b1;
                            mem.we    = 1'b1;
                            mem.addr  = request.pc;
                            mem.wdata = request.write_data;
                        end
                        ceau_pkg::MODE_ZP, ceau_pkg::MODE_ZPX, ceau_pkg::MODE_ZPY,
                        ceau_pkg::MODE_REL, ceau_pkg::MODE_ABS, ceau_pkg::MODE_ABX,
                        ceau_pkg::MODE_ABY, ceau_pkg::MODE_IND, ceau_pkg::MODE_IZX,
                        ceau_pkg::MODE_IZY:
                        begin
                            mem.en     = 1'b1;
                            mem.addr   = request.pc;
                            state_next = S_B0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_B0:
            begin
                state_next      = S_IDLE;
                fin.rsp.next_pc = npc_reg;
                case (mode_reg)
                    ceau_pkg::MODE_ZP:
                    begin
                        fin.valid              = 1'b1;
                        fin.rsp.target_address = {8'h00, rdata};
                    end
                    ceau_pkg::MODE_ZPX:
                    begin
                        fin.valid              = 1'b1;
                        fin.rsp.target_address = {8'h00, zp_x};
                    end
                    ceau_pkg::MODE_ZPY:
                    begin
                        fin.valid              = 1'b1;
                        fin.rsp.target_address = {8'h00, zp_y};
                    end
                    ceau_pkg::MODE_REL:
                    begin
                        fin.valid              = 1'b1;
                        fin.rsp.target_address = rel_target;
                    end
                    ceau_pkg::MODE_ABS, ceau_pkg::MODE_ABX, ceau_pkg::MODE_ABY,
                    ceau_pkg::MODE_IND:
                    begin
                        lo_next    = rdata;
                        mem.en     = 1'b1;
                        mem.addr   = npc_reg - 16'd1;
                        state_next = S_B1;
                    end
                    ceau_pkg::MODE_IZX:
                    begin
                        ptr_next   = {8'h00, zp_x};
                        mem.en     = 1'b1;
                        mem.addr   = {8'h00, zp_x};
                        state_next = S_P0;
                    end
                    ceau_pkg::MODE_IZY:
                    begin
                        ptr_next   = {8'h00, rdata};
                        mem.en     = 1'b1;
                        mem.addr   = {8'h00, rdata};
                        state_next = S_P0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_B1:
            begin
                state_next      = S_IDLE;
                fin.rsp.next_pc = npc_reg;
                case (mode_reg)
                    ceau_pkg::MODE_ABS:
                    begin
                        fin.valid              = 1'b1;
                        fin.rsp.target_address = word;
                    end
                    ceau_pkg::MODE_ABX, ceau_pkg::MODE_ABY:
                    begin
                        fin.valid               = 1'b1;
                        fin.rsp.target_address  = idx_sum;
                        fin.rsp.extra_cycle     = page_cross;
                    end
                    ceau_pkg::MODE_IND:
                    begin
                        ptr_next   = word;
                        mem.en     = 1'b1;
                        mem.addr   = word;
                        state_next = S_P0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_P0:
            begin
                // High pointer byte stays in the same page
                lo_next    = rdata;
                mem.en     = 1'b1;
                mem.addr   = {ptr_reg[15:8], ptr_reg[7:0] + 8'd1};
                state_next = S_P1;
            end
            S_P1:
            begin
                state_next      = S_IDLE;
                fin.valid       = 1'b1;
                fin.rsp.next_pc = npc_reg;
                if (mode_reg == ceau_pkg::MODE_IZY)
                begin
                    fin.rsp.target_address = idx_sum;
                    fin.rsp.extra_cycle    = page_cross;
                end
                else
                begin
                    fin.rsp.target_address = word;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold request operands and fetched bytes
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        npc_reg  <= npc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        lo_reg   <= lo_next;
        ptr_reg  <= ptr_next;
    end

    `CEAU_ASSERT_IMP(a_write_idle, clk, rst_n, mem.we, (state_reg == S_IDLE) && start, "memory write outside an accepted request")
    `CEAU_ASSERT_IMP(a_fin_ends, clk, rst_n, fin.valid, state_next == S_IDLE, "finish while sequence continues")
    `CEAU_ASSERT_IMP(a_p1_fin, clk, rst_n, state_reg == S_P1, fin.valid, "pointer walk ended without result")
    `CEAU_ASSERT_NXT(a_rd_start, clk, rst_n, start && !busy && request.mode >= ceau_pkg::MODE_ZP && request.mode <= ceau_pkg::MODE_IZY, state_reg == S_B0, "operand read not started")

endmodule
